/* hdl/adnp_pkg.sv */
// ============================================================================
// adnp_pkg
// Shared types and constants for the ASCII decimal number parser: character
// codes, parse phases, field widths and parameter defaults.
// ============================================================================
`default_nettype none

package adnp_pkg;

    // Parameter defaults.
    localparam int MANT_DIGITS_DEF = 18;
    localparam int EXP_MAX_DEF     = 999;

    // Fixed field widths.
    localparam int CH_W      = 8;
    localparam int SIG_W     = 60;
    localparam int DEXP_W    = 11;
    localparam int OUT_BITS  = 1 + SIG_W + DEXP_W + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Character codes.
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_E_LO  = 8'h65;
    localparam logic [CH_W-1:0] CH_E_UP  = 8'h45;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_POINT = 8'h2E;

    // Parse phases.
    typedef enum logic [2:0] {
        PH_WS,
        PH_INT,
        PH_FRAC,
        PH_EXPSTART,
        PH_EXPDIG,
        PH_DONE
    } t_phase;

endpackage

`default_nettype wire

/* hdl/adnp_step.sv */
// ============================================================================
// adnp_step
// Next-state logic of the parser: applies one character to the parse state.
// ============================================================================
`default_nettype none

module adnp_step #(
    parameter int MANT_DIGITS = adnp_pkg::MANT_DIGITS_DEF,
    parameter int EXP_MAX     = adnp_pkg::EXP_MAX_DEF
) (
    input  wire logic [adnp_pkg::CH_W-1:0]  i_ch,
    input  wire adnp_pkg::t_phase           i_phase,
    input  wire logic                       i_neg,
    input  wire logic [adnp_pkg::SIG_W-1:0] i_mant,
    input  wire logic [$clog2(MANT_DIGITS+1)-1:0] i_dcnt,
    input  wire logic [$clog2(MANT_DIGITS+1)-1:0] i_fcnt,
    input  wire logic                       i_eneg,
    input  wire logic [$clog2(EXP_MAX+1)-1:0] i_eacc,
    input  wire logic                       i_ovf,
    output adnp_pkg::t_phase                o_phase,
    output logic                            o_neg,
    output logic [adnp_pkg::SIG_W-1:0]      o_mant,
    output logic [$clog2(MANT_DIGITS+1)-1:0] o_dcnt,
    output logic [$clog2(MANT_DIGITS+1)-1:0] o_fcnt,
    output logic                            o_eneg,
    output logic [$clog2(EXP_MAX+1)-1:0]    o_eacc,
    output logic                            o_ovf
);

    localparam int CNT_W = $clog2(MANT_DIGITS + 1);
    localparam int EXP_W = $clog2(EXP_MAX + 1);
    localparam int VW    = $clog2(10 * EXP_MAX + 10);
    localparam logic [CNT_W-1:0] DIG_LIM = CNT_W'(MANT_DIGITS);
    localparam logic [VW-1:0]    EXP_LIM = VW'(EXP_MAX);

    logic                           is_digit;
    logic                           is_space;
    logic                           is_e;
    logic [3:0]                     dval;
    logic                           room;
    logic [adnp_pkg::SIG_W-1:0]     mant_next;
    logic [VW-1:0]                  exp_sum;

    // Character classes.
    assign is_digit = (i_ch >= adnp_pkg::CH_ZERO) && (i_ch <= adnp_pkg::CH_NINE);
    assign is_space = ((i_ch >= adnp_pkg::CH_TAB) && (i_ch <= adnp_pkg::CH_CR))
                      || (i_ch == adnp_pkg::CH_SPACE);
    assign is_e     = (i_ch == adnp_pkg::CH_E_LO) || (i_ch == adnp_pkg::CH_E_UP);
    assign dval     = 4'(i_ch - adnp_pkg::CH_ZERO);

    // Significand times ten plus the digit, and the same for the exponent.
    assign room      = i_dcnt < DIG_LIM;
    assign mant_next = (i_mant << 3) + (i_mant << 1) + adnp_pkg::SIG_W'(dval);
    assign exp_sum   = (VW'(i_eacc) << 3) + (VW'(i_eacc) << 1) + VW'(dval);

    // Phase transitions and accumulator updates.
    always_comb begin
        logic take_dig;
        logic take_frac;
        logic take_exp;

        take_dig  = 1'b0;
        take_frac = 1'b0;
        take_exp  = 1'b0;
        o_phase   = i_phase;
        o_neg     = i_neg;
        o_eneg    = i_eneg;

        case (i_phase)
            adnp_pkg::PH_WS: begin
                if (is_space) begin
                    o_phase = adnp_pkg::PH_WS;
                end else if (i_ch == adnp_pkg::CH_MINUS) begin
                    o_neg   = 1'b1;
                    o_phase = adnp_pkg::PH_INT;
                end else if (i_ch == adnp_pkg::CH_PLUS) begin
                    o_phase = adnp_pkg::PH_INT;
                end else if (is_digit) begin
                    take_dig = 1'b1;
                    o_phase  = adnp_pkg::PH_INT;
                end else if (i_ch == adnp_pkg::CH_POINT) begin
                    o_phase = adnp_pkg::PH_FRAC;
                end else if (is_e) begin
                    o_phase = adnp_pkg::PH_EXPSTART;
                end else begin
                    o_phase = adnp_pkg::PH_DONE;
                end
            end
            adnp_pkg::PH_INT: begin
                if (is_digit) begin
                    take_dig = 1'b1;
                end else if (i_ch == adnp_pkg::CH_POINT) begin
                    o_phase = adnp_pkg::PH_FRAC;
                end else if (is_e) begin
                    o_phase = adnp_pkg::PH_EXPSTART;
                end else begin
                    o_phase = adnp_pkg::PH_DONE;
                end
            end
            adnp_pkg::PH_FRAC: begin
                if (is_digit) begin
                    take_dig  = 1'b1;
                    take_frac = 1'b1;
                end else if (is_e) begin
                    o_phase = adnp_pkg::PH_EXPSTART;
                end else begin
                    o_phase = adnp_pkg::PH_DONE;
                end
            end
            adnp_pkg::PH_EXPSTART: begin
                if (i_ch == adnp_pkg::CH_MINUS) begin
                    o_eneg  = 1'b1;
                    o_phase = adnp_pkg::PH_EXPDIG;
                end else if (i_ch == adnp_pkg::CH_PLUS) begin
                    o_phase = adnp_pkg::PH_EXPDIG;
                end else if (is_digit) begin
                    take_exp = 1'b1;
                    o_phase  = adnp_pkg::PH_EXPDIG;
                end else begin
                    o_phase = adnp_pkg::PH_DONE;
                end
            end
            adnp_pkg::PH_EXPDIG: begin
                if (is_digit) begin
                    take_exp = 1'b1;
                end else begin
                    o_phase = adnp_pkg::PH_DONE;
                end
            end
            default: begin
                o_phase = adnp_pkg::PH_DONE;
            end
        endcase

        // Digit accumulation: digits past the limit are dropped and flagged.
        o_mant = i_mant;
        o_dcnt = i_dcnt;
        o_fcnt = i_fcnt;
        o_eacc = i_eacc;
        o_ovf  = i_ovf;
        if (take_dig) begin
            if (room) begin
                o_mant = mant_next;
                o_dcnt = i_dcnt + CNT_W'(1);
                if (take_frac) begin
                    o_fcnt = i_fcnt + CNT_W'(1);
                end
            end else begin
                o_ovf = 1'b1;
            end
        end

        // Exponent accumulation saturates at its maximum.
        if (take_exp) begin
            if (exp_sum > EXP_LIM) begin
                o_eacc = EXP_W'(EXP_MAX);
                o_ovf  = 1'b1;
            end else begin
                o_eacc = EXP_W'(exp_sum);
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/adnp_result.sv */
// ============================================================================
// adnp_result
// Result stage: forms the net decimal exponent and holds the result item
// until the downstream side takes it.
// ============================================================================
`default_nettype none

module adnp_result #(
    parameter int MANT_DIGITS = adnp_pkg::MANT_DIGITS_DEF,
    parameter int EXP_MAX     = adnp_pkg::EXP_MAX_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_load,
    input  wire logic                       i_neg,
    input  wire logic [adnp_pkg::SIG_W-1:0] i_mant,
    input  wire logic [$clog2(MANT_DIGITS+1)-1:0] i_fcnt,
    input  wire logic                       i_eneg,
    input  wire logic [$clog2(EXP_MAX+1)-1:0] i_eacc,
    input  wire logic                       i_ovf,
    input  wire logic                       i_m_tready,
    output logic                            o_m_tvalid,
    output logic [adnp_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int CNT_W = $clog2(MANT_DIGITS + 1);
    localparam int EXP_W = $clog2(EXP_MAX + 1);
    localparam int XW0   = (EXP_W > CNT_W) ? EXP_W + 1 : CNT_W + 1;
    localparam int XW    = (XW0 > adnp_pkg::DEXP_W) ? XW0 : adnp_pkg::DEXP_W;
    localparam int PAD_W = adnp_pkg::OUT_TDATA_W - adnp_pkg::OUT_BITS;

    logic [XW-1:0]                  e_mag;
    logic [XW-1:0]                  e_signed;
    logic [XW-1:0]                  e_net;
    logic                           r_valid;
    logic                           r_neg;
    logic [adnp_pkg::SIG_W-1:0]     r_sig;
    logic [adnp_pkg::DEXP_W-1:0]    r_dexp;
    logic                           r_ovf;

    // Net exponent, kept modulo the output width.
    assign e_mag    = XW'(i_eacc);
    assign e_signed = i_eneg ? (~e_mag + XW'(1)) : e_mag;
    assign e_net    = e_signed - XW'(i_fcnt);

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_neg  <= i_neg;
            r_sig  <= i_mant;
            r_dexp <= e_net[adnp_pkg::DEXP_W-1:0];
            r_ovf  <= i_ovf;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_ovf, r_dexp, r_sig, r_neg};

endmodule

`default_nettype wire

/* hdl/ascii_decimal_number_parser_unit.sv */
// ============================================================================
// ascii_decimal_number_parser_unit
// Parses a decimal number in scientific notation, one ASCII character per
// item, and emits sign, significand and net decimal exponent at end of line.
// ============================================================================
//
//  Channel   Direction  Fields (lowest bit first)
//  s_axis    in         tdata: ch[7:0]; tlast: last
//  m_axis    out        tdata: negative[0], significand[60:1],
//                              dec_exponent[71:61], overflow[72], zeros[79:73]
//
//  One character is taken every cycle unless the input stalls; the parse state
//  loop (times ten plus digit on the significand) is combinational.
//  A result is valid once the last character has passed the input register and the result register.
//  Input stalls only while a last character waits for a full result register.
//  Reset returns the parser to the leading whitespace phase with empty sums.
//
`default_nettype none

module ascii_decimal_number_parser_unit #(
    parameter int MANT_DIGITS = adnp_pkg::MANT_DIGITS_DEF,
    parameter int EXP_MAX     = adnp_pkg::EXP_MAX_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire logic [adnp_pkg::CH_W-1:0]   i_s_axis_tdata,  // ch
    input  wire logic                        i_s_axis_tlast,  // last
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    output logic [adnp_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata   // negative, significand,
                                                              // dec_exponent, overflow
);

    localparam int CNT_W = $clog2(MANT_DIGITS + 1);
    localparam int EXP_W = $clog2(EXP_MAX + 1);

    logic                       r_in_valid;
    logic [adnp_pkg::CH_W-1:0]  r_in_ch;
    logic                       r_in_last;
    logic                       advance;
    logic                       step_en;

    adnp_pkg::t_phase           r_phase;
    logic                       r_neg;
    logic [adnp_pkg::SIG_W-1:0] r_mant;
    logic [CNT_W-1:0]           r_dcnt;
    logic [CNT_W-1:0]           r_fcnt;
    logic                       r_eneg;
    logic [EXP_W-1:0]           r_eacc;
    logic                       r_ovf;

    adnp_pkg::t_phase           n_phase;
    logic                       n_neg;
    logic [adnp_pkg::SIG_W-1:0] n_mant;
    logic [CNT_W-1:0]           n_dcnt;
    logic [CNT_W-1:0]           n_fcnt;
    logic                       n_eneg;
    logic [EXP_W-1:0]           n_eacc;
    logic                       n_ovf;

    // The input register moves on unless a last item must wait for the
    // result register to drain.
    assign advance = !(r_in_valid && r_in_last && o_m_axis_tvalid && !i_m_axis_tready);
    assign step_en = r_in_valid && advance;
    assign o_s_axis_tready = advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_s_axis_tvalid) begin
            r_in_ch   <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // Character step logic.
    adnp_step #(
        .MANT_DIGITS (MANT_DIGITS),
        .EXP_MAX     (EXP_MAX)
    ) u_step (
        .i_ch    (r_in_ch),
        .i_phase (r_phase),
        .i_neg   (r_neg),
        .i_mant  (r_mant),
        .i_dcnt  (r_dcnt),
        .i_fcnt  (r_fcnt),
        .i_eneg  (r_eneg),
        .i_eacc  (r_eacc),
        .i_ovf   (r_ovf),
        .o_phase (n_phase),
        .o_neg   (n_neg),
        .o_mant  (n_mant),
        .o_dcnt  (n_dcnt),
        .o_fcnt  (n_fcnt),
        .o_eneg  (n_eneg),
        .o_eacc  (n_eacc),
        .o_ovf   (n_ovf)
    );

    // Parse state; it starts over after the last item of a line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (step_en && r_in_last)) begin
            r_phase <= adnp_pkg::PH_WS;
            r_neg   <= 1'b0;
            r_mant  <= '0;
            r_dcnt  <= '0;
            r_fcnt  <= '0;
            r_eneg  <= 1'b0;
            r_eacc  <= '0;
            r_ovf   <= 1'b0;
        end else if (step_en) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_mant  <= n_mant;
            r_dcnt  <= n_dcnt;
            r_fcnt  <= n_fcnt;
            r_eneg  <= n_eneg;
            r_eacc  <= n_eacc;
            r_ovf   <= n_ovf;
        end
    end

    // Result register, loaded from the state after the last character.
    adnp_result #(
        .MANT_DIGITS (MANT_DIGITS),
        .EXP_MAX     (EXP_MAX)
    ) u_result (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step_en && r_in_last),
        .i_neg      (n_neg),
        .i_mant     (n_mant),
        .i_fcnt     (n_fcnt),
        .i_eneg     (n_eneg),
        .i_eacc     (n_eacc),
        .i_ovf      (n_ovf),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_tdata  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

/* sim/number_parse_checker.sv */
// ============================================================================
// number_parse_checker
// Watches both stream channels of the ASCII decimal number parser. It
// re-parses every accepted character, queues the number due at each end of
// line, and compares every emitted number field by field against the oldest
// one due.
// ============================================================================

module number_parse_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_tvalid,
    input  wire logic                             i_in_tready,
    input  wire logic [adnp_pkg::CH_W-1:0]        i_in_tdata,   // ch
    input  wire logic                             i_in_tlast,   // last
    input  wire logic                             i_out_tvalid,
    input  wire logic                             i_out_tready,
    input  wire logic [adnp_pkg::OUT_TDATA_W-1:0] i_out_tdata,  // negative, significand,
                                                                 // dec_exponent, overflow
    output int                                    o_fail_count,
    output int                                    o_pending
);
    import adnp_pkg::*;

    localparam int SIG_LIMIT  = MANT_DIGITS_DEF;
    localparam int EXP_LIMIT  = EXP_MAX_DEF;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic                     neg;
        logic [SIG_W-1:0]         sig;
        logic signed [DEXP_W-1:0] dexp;
        logic                     ovf;
    } number_t;

    // Parser state as this checker sees it.
    t_phase      scan_phase;
    logic        seen_minus;
    logic [63:0] sig_acc;
    int unsigned sig_digits;
    int unsigned frac_digits;
    logic        exp_minus;
    int unsigned exp_mag;
    logic        lost_precision;

    number_t numbers_due[$];
    int      fails = 0;

    task automatic clear_scan();
        scan_phase     = PH_WS;
        seen_minus     = 1'b0;
        sig_acc        = '0;
        sig_digits     = 0;
        frac_digits    = 0;
        exp_minus      = 1'b0;
        exp_mag        = 0;
        lost_precision = 1'b0;
    endtask

    // Every digit counts toward the limit; digits past it are only flagged.
    task automatic add_sig_digit(input logic [CH_W-1:0] c, input logic in_frac);
        if (sig_digits < SIG_LIMIT) begin
            sig_acc = sig_acc * 10 + 64'(c - CH_ZERO);
            sig_digits++;
            if (in_frac) begin
                frac_digits++;
            end
        end else begin
            lost_precision = 1'b1;
        end
    endtask

    // The exponent magnitude saturates at its limit.
    task automatic add_exp_digit(input logic [CH_W-1:0] c);
        int unsigned v;
        v = exp_mag * 10 + 32'(c - CH_ZERO);
        if (v > EXP_LIMIT) begin
            v = EXP_LIMIT;
            lost_precision = 1'b1;
        end
        exp_mag = v;
    endtask

    task automatic scan_char(input logic [CH_W-1:0] c);
        logic is_dig;
        logic is_ws;
        logic is_exp;
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        is_ws  = ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
        is_exp = (c == CH_E_LO) || (c == CH_E_UP);
        case (scan_phase)
            PH_WS: begin
                if (!is_ws) begin
                    if (c == CH_MINUS) begin
                        seen_minus = 1'b1;
                        scan_phase = PH_INT;
                    end else if (c == CH_PLUS) begin
                        scan_phase = PH_INT;
                    end else if (is_dig) begin
                        add_sig_digit(c, 1'b0);
                        scan_phase = PH_INT;
                    end else if (c == CH_POINT) begin
                        scan_phase = PH_FRAC;
                    end else if (is_exp) begin
                        scan_phase = PH_EXPSTART;
                    end else begin
                        scan_phase = PH_DONE;
                    end
                end
            end
            PH_INT: begin
                if (is_dig) begin
                    add_sig_digit(c, 1'b0);
                end else if (c == CH_POINT) begin
                    scan_phase = PH_FRAC;
                end else if (is_exp) begin
                    scan_phase = PH_EXPSTART;
                end else begin
                    scan_phase = PH_DONE;
                end
            end
            PH_FRAC: begin
                if (is_dig) begin
                    add_sig_digit(c, 1'b1);
                end else if (is_exp) begin
                    scan_phase = PH_EXPSTART;
                end else begin
                    scan_phase = PH_DONE;
                end
            end
            PH_EXPSTART: begin
                if (c == CH_MINUS) begin
                    exp_minus  = 1'b1;
                    scan_phase = PH_EXPDIG;
                end else if (c == CH_PLUS) begin
                    scan_phase = PH_EXPDIG;
                end else if (is_dig) begin
                    add_exp_digit(c);
                    scan_phase = PH_EXPDIG;
                end else begin
                    scan_phase = PH_DONE;
                end
            end
            PH_EXPDIG: begin
                if (is_dig) begin
                    add_exp_digit(c);
                end else begin
                    scan_phase = PH_DONE;
                end
            end
            default: begin
                scan_phase = PH_DONE;
            end
        endcase
    endtask

    // Outputs are compared before inputs are parsed: a number emitted at an
    // edge always belongs to an earlier end of line.
    always @(posedge i_clk) begin
        number_t got;
        number_t want;
        int      net_exp;
        if (!i_rst_n) begin
            clear_scan();
            numbers_due.delete();
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                got.neg  = i_out_tdata[0];
                got.sig  = i_out_tdata[SIG_W:1];
                got.dexp = i_out_tdata[SIG_W+DEXP_W:SIG_W+1];
                got.ovf  = i_out_tdata[SIG_W+DEXP_W+1];
                if (numbers_due.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX) begin
                        $display("%0t: number emitted with none due: neg=%0b sig=%0d dexp=%0d ovf=%0b",
                                 $realtime, got.neg, got.sig, $signed(got.dexp), got.ovf);
                    end
                end else begin
                    want = numbers_due.pop_front();
                    if (got.neg !== want.neg || got.sig !== want.sig ||
                        got.dexp !== want.dexp || got.ovf !== want.ovf) begin
                        fails++;
                        if (fails <= REPORT_MAX) begin
                            $display("%0t: number mismatch: expected neg=%0b sig=%0d dexp=%0d ovf=%0b",
                                     $realtime, want.neg, want.sig, $signed(want.dexp), want.ovf);
                            $display("%0t:                  actual   neg=%0b sig=%0d dexp=%0d ovf=%0b",
                                     $realtime, got.neg, got.sig, $signed(got.dexp), got.ovf);
                        end
                    end
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                scan_char(i_in_tdata);
                // End of line: the character is parsed first, then the number is due.
                if (i_in_tlast) begin
                    net_exp = exp_minus ? -int'(exp_mag) : int'(exp_mag);
                    net_exp = net_exp - int'(frac_digits);
                    want.neg  = seen_minus;
                    want.sig  = sig_acc[SIG_W-1:0];
                    want.dexp = net_exp[DEXP_W-1:0];
                    want.ovf  = lost_precision;
                    numbers_due.push_back(want);
                    clear_scan();
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= numbers_due.size();
    end

endmodule

/* sim/ascii_decimal_number_parser_unit_tb.sv */
// ============================================================================
// ascii_decimal_number_parser_unit_tb
// Feeds the number parser with a few hand-written lines, then with random
// lines that are mostly well-formed numbers, some broken and some noise.
// Both stream sides idle at random; a checker beside the block predicts
// and compares every emitted number.
// ============================================================================

module ascii_decimal_number_parser_unit_tb;
    import adnp_pkg::*;

    localparam int TARGET_ITEMS = 1200;
    localparam int HOLD_CYCLES  = 200;
    localparam int LIMIT_CYCLES = 300000;
    localparam int CLK_PERIOD   = 12;
    localparam int SETTLE_CYCLES = 20;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic [CH_W-1:0]        i_s_axis_tdata  = '0;
    logic                   i_s_axis_tlast  = 1'b0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    int mismatches;
    int awaiting;

    logic [CH_W-1:0] line_buf[$];
    int              chars_sent = 0;
    logic            line_fast  = 1'b0;

    ascii_decimal_number_parser_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    number_parse_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (i_s_axis_tvalid),
        .i_in_tready  (o_s_axis_tready),
        .i_in_tdata   (i_s_axis_tdata),
        .i_in_tlast   (i_s_axis_tlast),
        .i_out_tvalid (o_m_axis_tvalid),
        .i_out_tready (i_m_axis_tready),
        .i_out_tdata  (o_m_axis_tdata),
        .o_fail_count (mismatches),
        .o_pending    (awaiting)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // One character item, with a random gap unless the line runs at full rate.
    task automatic send_char(input logic [CH_W-1:0] c, input logic end_of_line);
        int gap;
        gap = line_fast ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        i_s_axis_tlast  <= end_of_line;
        do @(posedge i_clk); while (!o_s_axis_tready);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input logic closes);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], closes && (i == s.len() - 1));
        end
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++) begin
            send_char(line_buf[i], i == line_buf.size() - 1);
        end
    endtask

    // Stop offering items until every number due has been emitted.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (awaiting != 0) @(posedge i_clk);
    endtask

    task automatic push_digits(input int n);
        repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Mostly short digit runs, sometimes long enough to pass the digit limit.
    function automatic int digit_run();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            return $urandom_range(0, 4);
        end else if (r < 9) begin
            return $urandom_range(5, 12);
        end
        return $urandom_range(15, 24);
    endfunction

    // A well-formed number with random content, sometimes with trailing junk.
    task automatic compose_number();
        int r;
        line_buf.delete();
        repeat ($urandom_range(0, 2)) begin
            r = $urandom_range(0, 5);
            line_buf.push_back((r == 5) ? CH_SPACE : CH_TAB + 8'(r));
        end
        case ($urandom_range(0, 2))
            0: line_buf.push_back(CH_MINUS);
            1: line_buf.push_back(CH_PLUS);
            default: ;
        endcase
        push_digits(digit_run());
        if ($urandom_range(0, 1) == 1) begin
            line_buf.push_back(CH_POINT);
            push_digits(digit_run());
        end
        if ($urandom_range(0, 2) != 0) begin
            line_buf.push_back(($urandom_range(0, 1) == 1) ? CH_E_LO : CH_E_UP);
            case ($urandom_range(0, 2))
                0: line_buf.push_back(CH_MINUS);
                1: line_buf.push_back(CH_PLUS);
                default: ;
            endcase
            push_digits($urandom_range(0, 4));
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
        end
        if (line_buf.size() == 0) begin
            push_digits(1);
        end
    endtask

    // Result side: random stalls, runs without stalls, and two long hold-offs.
    initial begin : result_sink
        int stall;
        int taken;
        int calm_left;
        taken     = 0;
        calm_left = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken == 15 || taken == 60) begin
                stall = HOLD_CYCLES;
            end else if (calm_left > 0) begin
                stall = 0;
                calm_left--;
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    calm_left = $urandom_range(5, 15);
                end
                stall = $urandom_range(0, 8);
            end
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_axis_tvalid && i_m_axis_tready));
            taken++;
        end
    end

    // Character side: directed lines, random lines, then the verdict.
    initial begin : char_source
        int   r;
        int   pos;
        logic paused_mid;
        paused_mid = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Vertical tab, minus, point, upper E and a negative exponent.
        send_char(8'h0B, 1'b0);
        send_text("-7.5E-9", 1'b1);
        // Lowest code on its own stops the parse at once.
        send_char(8'h00, 1'b1);
        // Exponent with no significand digits.
        send_text("e5", 1'b1);
        // Stopped parse after a bare exponent sign, closed by the highest code.
        send_char(CH_CR, 1'b0);
        send_text("+3e+", 1'b0);
        send_char(8'hFF, 1'b1);
        // Sign only.
        send_text("-", 1'b1);
        // Exponent saturation.
        send_text("9e9999", 1'b1);
        drain();

        while (chars_sent < TARGET_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                // Noise line.
                line_buf.delete();
                repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
                compose_number();
                // Broken line: one character replaced or the tail cut off.
                if (r <= 2) begin
                    pos = $urandom_range(0, line_buf.size() - 1);
                    if ($urandom_range(0, 1) == 1) begin
                        line_buf[pos] = 8'($urandom_range(0, 255));
                    end else begin
                        while (line_buf.size() > pos + 1) void'(line_buf.pop_back());
                    end
                end
            end
            line_fast = ($urandom_range(0, 3) == 0);
            send_line();
            if (!paused_mid && chars_sent >= TARGET_ITEMS / 2) begin
                paused_mid = 1'b1;
                drain();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && awaiting == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
